>>> hw/rtl/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

    localparam logic [15:0] BMP_SIGNATURE  = 16'h424D;
    localparam logic [15:0] BMP_DEPTH_24   = 16'd24;
    localparam logic [31:0] HEADER_LAST    = 32'd37;
    localparam logic [31:0] DATA_MIN_START = 32'd38;

    localparam logic [11:0] SCREEN_W_RESET = 12'd320;
    localparam logic [11:0] SCREEN_H_RESET = 12'd240;
    localparam logic [3:0]  MAX_SKIP_RESET = 4'd4;

    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_MAX_SKIP = 2'd2;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_WINDOW = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] REJ_SIGNATURE  = 3'd0;
    localparam logic [2:0] REJ_COMPRESSED = 3'd1;
    localparam logic [2:0] REJ_NO_DATA    = 3'd2;
    localparam logic [2:0] REJ_DEPTH      = 3'd3;
    localparam logic [2:0] REJ_TOO_LARGE  = 3'd4;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel;
        logic [11:0] x_start;
        logic [11:0] y_start;
        logic [11:0] x_end;
        logic [11:0] y_end;
        logic [2:0]  reject_code;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [11:0] screen_w;
        logic [11:0] screen_h;
        logic [3:0]  max_skip;
    } cfg_t;

    typedef enum logic [1:0] {
        DIV_SRC_W = 2'd0,
        DIV_SRC_H = 2'd1,
        DIV_SRC_S = 2'd2
    } div_src_t;

    typedef struct packed {
        logic       accept;
        logic       hdr_step;
        logic       data_step;
        logic       k_clear;
        logic       k_inc;
        logic       div_go;
        div_src_t   div_src;
        logic       cap_w;
        logic       cap_h;
        logic       cap_s;
        logic       emit_window;
        logic       emit_reject;
        logic [2:0] reject_code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first_byte;
        logic hdr_done;
        logic data_live;
        logic data_end;
        logic sig_ok;
        logic comp_ok;
        logic size_ok;
        logic depth_ok;
        logic fits;
        logic k_at_max;
        logic div_done;
        logic stride_zero;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/bmp_stream_decimate_to_rgb565_unit.sv
`timescale 1ns / 1ps
// one file byte per cycle through header and pixel data while output is free, result registered
// after header byte 37 the input is held off for the header checks, a skip search over
// k = 0 to max_skip, three divisions in the shared divider and the window word; a
// rejected header ends the hold-off with its reject word
// a finished word waits in the output register and the next byte is taken only as it leaves
// reset (rst_n low, asynchronous): header parsing from byte offset zero, output empty,
// screen 320 x 240, max_skip 4

module bmp_stream_decimate_to_rgb565_unit
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  in_word_t              byte_word,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_word_t             result_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign pready = 1'b1;

    bsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bsd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .byte_word    (byte_word),
        .result_word  (result_word),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

>>> hw/rtl/bsd_regs.sv
`timescale 1ns / 1ps

module bsd_regs
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index = paddr[CFG_ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_w <= SCREEN_W_RESET;
            cfg_reg.screen_h <= SCREEN_H_RESET;
            cfg_reg.max_skip <= MAX_SKIP_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_SCREEN_W: cfg_reg.screen_w <= pwdata[11:0];
                REG_SCREEN_H: cfg_reg.screen_h <= pwdata[11:0];
                REG_MAX_SKIP: cfg_reg.max_skip <= pwdata[3:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SCREEN_W: prdata = {20'd0, cfg_reg.screen_w};
            REG_SCREEN_H: prdata = {20'd0, cfg_reg.screen_h};
            REG_MAX_SKIP: prdata = {28'd0, cfg_reg.max_skip};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/bsd_divider.sv
`timescale 1ns / 1ps

module bsd_divider
    import bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvsr_reg;

    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[31]};
        diff   = rem_sh - {1'b0, dvsr_reg};
        ge     = rem_sh >= {1'b0, dvsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg  <= 32'd0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : rem_sh[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/bsd_datapath.sv
`timescale 1ns / 1ps

module bsd_datapath
    import bsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  cfg_t       cfg,
    input  in_word_t   byte_word,
    output out_word_t  result_word,
    output logic       result_valid,
    input  logic       result_ready
);

    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;

    logic [31:0] pos_reg;
    logic [31:0] hdr_offset_reg;
    logic [31:0] hdr_width_reg;
    logic [31:0] hdr_height_reg;
    logic [31:0] hdr_depth_reg;
    logic [31:0] hdr_comp_reg;
    logic [31:0] hdr_size_reg;

    logic [3:0]  k_reg;
    logic [11:0] scaled_w_reg;
    logic [11:0] scaled_h_reg;
    logic [31:0] stride_reg;
    logic [15:0] row_count_reg;
    logic [3:0]  row_mod_reg;
    logic [31:0] bir_reg;
    logic [1:0]  lane_reg;
    logic [3:0]  col_mod_reg;
    logic [12:0] col_div_reg;
    logic [15:0] held_reg;

    out_word_t   result_word_reg;
    out_word_t   result_word_next;
    logic        result_valid_reg;
    logic        result_valid_next;

    logic [31:0] eff_pos;
    logic [31:0] pos_next;
    logic [31:0] data_start;
    logic        data_fire;
    logic [7:0]  b;
    logic [4:0]  k1;
    logic [17:0] w_lim;
    logic [17:0] h_lim;
    logic        bir_end;
    logic        row_last;
    logic        pix_hit;
    logic        pix_last;
    logic [16:0] row_reach;
    logic [12:0] sum_x;
    logic [12:0] sum_y;
    logic [11:0] diff_x;
    logic [11:0] diff_y;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;

    assign b         = byte_word.file_byte;
    assign eff_pos   = byte_word.first_byte ? 32'd0 : pos_reg;
    assign pos_next  = (eff_pos == 32'hFFFF_FFFF) ? eff_pos : eff_pos + 32'd1;
    assign data_start = (hdr_offset_reg < DATA_MIN_START) ? DATA_MIN_START : hdr_offset_reg;
    assign data_fire = cmd.data_step & (eff_pos >= data_start);
    assign k1        = {1'b0, k_reg} + 5'd1;

    // fit test: w / k1 <= sw  is  w < (sw + 1) * k1
    assign w_lim = ({6'd0, cfg.screen_w} + 18'd1) * {13'd0, k1};
    assign h_lim = ({6'd0, cfg.screen_h} + 18'd1) * {13'd0, k1};

    assign bir_end   = ({1'b0, bir_reg} + 33'd1) >= {1'b0, stride_reg};
    assign row_last  = ({16'd0, row_count_reg} + 32'd1) >= hdr_height_reg;
    assign row_reach = {1'b0, row_count_reg} + {12'd0, k1};

    assign pix_hit  = (lane_reg == LANE_RED) && (row_mod_reg == 4'd0) &&
                      (col_mod_reg == 4'd0) && (col_div_reg < {1'b0, scaled_w_reg});
    assign pix_last = ({15'd0, row_reach} >= hdr_height_reg) &&
                      (col_div_reg == {1'b0, scaled_w_reg - 12'd1});

    assign sum_x  = {1'b0, cfg.screen_w} + {1'b0, scaled_w_reg};
    assign sum_y  = {1'b0, cfg.screen_h} + {1'b0, scaled_h_reg};
    assign diff_x = cfg.screen_w - scaled_w_reg;
    assign diff_y = cfg.screen_h - scaled_h_reg;

    always_comb
    begin
        case (cmd.div_src)
            DIV_SRC_W:
            begin
                div_dividend = hdr_width_reg;
                div_divisor  = {27'd0, k1};
            end
            DIV_SRC_H:
            begin
                div_dividend = hdr_height_reg;
                div_divisor  = {27'd0, k1};
            end
            default:
            begin
                div_dividend = hdr_size_reg;
                div_divisor  = hdr_height_reg;
            end
        endcase
    end

    bsd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 32'd0;
        end
        else if (cmd.accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // header capture, little-endian, signature in the top half of the depth word
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_step)
        begin
            case (eff_pos[5:0])
                6'd0:  hdr_depth_reg[31:24]  <= b;
                6'd1:  hdr_depth_reg[23:16]  <= b;
                6'd10: hdr_offset_reg[7:0]   <= b;
                6'd11: hdr_offset_reg[15:8]  <= b;
                6'd12: hdr_offset_reg[23:16] <= b;
                6'd13: hdr_offset_reg[31:24] <= b;
                6'd18: hdr_width_reg[7:0]    <= b;
                6'd19: hdr_width_reg[15:8]   <= b;
                6'd20: hdr_width_reg[23:16]  <= b;
                6'd21: hdr_width_reg[31:24]  <= b;
                6'd22: hdr_height_reg[7:0]   <= b;
                6'd23: hdr_height_reg[15:8]  <= b;
                6'd24: hdr_height_reg[23:16] <= b;
                6'd25: hdr_height_reg[31:24] <= b;
                6'd28: hdr_depth_reg[7:0]    <= b;
                6'd29: hdr_depth_reg[15:8]   <= b;
                6'd30: hdr_comp_reg[7:0]     <= b;
                6'd31: hdr_comp_reg[15:8]    <= b;
                6'd32: hdr_comp_reg[23:16]   <= b;
                6'd33: hdr_comp_reg[31:24]   <= b;
                6'd34: hdr_size_reg[7:0]     <= b;
                6'd35: hdr_size_reg[15:8]    <= b;
                6'd36: hdr_size_reg[23:16]   <= b;
                6'd37: hdr_size_reg[31:24]   <= b;
                default: hdr_size_reg <= hdr_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 4'd0;
        end
        else if (cmd.k_clear)
        begin
            k_reg <= 4'd0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_w)
        begin
            scaled_w_reg <= div_quotient[11:0];
        end
        if (cmd.cap_h)
        begin
            scaled_h_reg <= div_quotient[11:0];
        end
        if (cmd.cap_s)
        begin
            stride_reg <= div_quotient;
        end
        if (data_fire && (lane_reg == LANE_BLUE))
        begin
            held_reg[7:0] <= b;
        end
        if (data_fire && (lane_reg == LANE_GREEN))
        begin
            held_reg[15:8] <= b;
        end
    end

    // row and column walk over the pixel data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 16'd0;
            row_mod_reg   <= 4'd0;
            bir_reg       <= 32'd0;
            lane_reg      <= LANE_BLUE;
            col_mod_reg   <= 4'd0;
            col_div_reg   <= 13'd0;
        end
        else if (cmd.emit_window)
        begin
            row_count_reg <= 16'd0;
            row_mod_reg   <= 4'd0;
            bir_reg       <= 32'd0;
            lane_reg      <= LANE_BLUE;
            col_mod_reg   <= 4'd0;
            col_div_reg   <= 13'd0;
        end
        else if (data_fire)
        begin
            if (bir_end)
            begin
                bir_reg       <= 32'd0;
                lane_reg      <= LANE_BLUE;
                col_mod_reg   <= 4'd0;
                col_div_reg   <= 13'd0;
                row_count_reg <= row_count_reg + 16'd1;
                row_mod_reg   <= (row_mod_reg == k_reg) ? 4'd0 : row_mod_reg + 4'd1;
            end
            else
            begin
                bir_reg <= bir_reg + 32'd1;
                if (lane_reg == LANE_RED)
                begin
                    lane_reg <= LANE_BLUE;
                    if (col_mod_reg == k_reg)
                    begin
                        col_mod_reg <= 4'd0;
                        if (col_div_reg != 13'h1FFF)
                        begin
                            col_div_reg <= col_div_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        col_mod_reg <= col_mod_reg + 4'd1;
                    end
                end
                else
                begin
                    lane_reg <= lane_reg + 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        result_word_next = result_word_reg;
        if (cmd.emit_reject)
        begin
            result_word_next             = '0;
            result_word_next.kind        = KIND_REJECT;
            result_word_next.reject_code = cmd.reject_code;
        end
        else if (cmd.emit_window)
        begin
            result_word_next         = '0;
            result_word_next.kind    = KIND_WINDOW;
            result_word_next.x_start = {1'b0, diff_x[11:1]};
            result_word_next.y_start = {1'b0, diff_y[11:1]};
            result_word_next.x_end   = sum_x[12:1] - 12'd1;
            result_word_next.y_end   = sum_y[12:1];
        end
        else if (data_fire && pix_hit)
        begin
            result_word_next       = '0;
            result_word_next.kind  = KIND_PIXEL;
            result_word_next.pixel = {b[7:3], held_reg[15:10], held_reg[7:3]};
            result_word_next.last  = pix_last;
        end
    end

    assign result_valid_next = cmd.emit_reject | cmd.emit_window | (data_fire & pix_hit) |
                               (result_valid_reg & ~result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_word_reg <= result_word_next;
    end

    assign result_word  = result_word_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        status.first_byte  = byte_word.first_byte;
        status.hdr_done    = eff_pos == HEADER_LAST;
        status.data_live   = eff_pos >= data_start;
        status.data_end    = bir_end & row_last;
        status.sig_ok      = hdr_depth_reg[31:16] == BMP_SIGNATURE;
        status.comp_ok     = hdr_comp_reg == 32'd0;
        status.size_ok     = (hdr_size_reg != 32'd0) && (hdr_height_reg != 32'd0);
        status.depth_ok    = hdr_depth_reg[15:0] == BMP_DEPTH_24;
        status.fits        = (hdr_width_reg < {14'd0, w_lim}) &&
                             (hdr_height_reg < {14'd0, h_lim});
        status.k_at_max    = k_reg == cfg.max_skip;
        status.div_done    = div_done;
        status.stride_zero = stride_reg == 32'd0;
        status.out_free    = ~result_valid_reg | result_ready;
    end

endmodule

>>> hw/rtl/bsd_ctrl.sv
`timescale 1ns / 1ps

module bsd_ctrl
    import bsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_HEADER = 9'b000000001,
        S_DATA   = 9'b000000010,
        S_IDLE   = 9'b000000100,
        S_CHECK  = 9'b000001000,
        S_SEARCH = 9'b000010000,
        S_DIV_W  = 9'b000100000,
        S_DIV_H  = 9'b001000000,
        S_DIV_S  = 9'b010000000,
        S_WINDOW = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   streaming;
    logic   accept;

    assign streaming  = (state_reg == S_HEADER) || (state_reg == S_DATA) ||
                        (state_reg == S_IDLE);
    assign byte_ready = streaming & status.out_free;
    assign accept     = byte_valid & byte_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.div_src     = DIV_SRC_S;
        cmd.accept      = accept;
        case (state_reg)
            S_HEADER, S_DATA, S_IDLE:
            begin
                if (accept)
                begin
                    if (status.first_byte || (state_reg == S_HEADER))
                    begin
                        cmd.hdr_step = 1'b1;
                        state_next   = status.hdr_done ? S_CHECK : S_HEADER;
                    end
                    else if (state_reg == S_DATA)
                    begin
                        cmd.data_step = 1'b1;
                        if (status.data_live && status.data_end)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (!status.sig_ok)
                begin
                    cmd.emit_reject = 1'b1;
                    cmd.reject_code = REJ_SIGNATURE;
                end
                else if (!status.comp_ok)
                begin
                    cmd.emit_reject = 1'b1;
                    cmd.reject_code = REJ_COMPRESSED;
                end
                else if (!status.size_ok)
                begin
                    cmd.emit_reject = 1'b1;
                    cmd.reject_code = REJ_NO_DATA;
                end
                else if (!status.depth_ok)
                begin
                    cmd.emit_reject = 1'b1;
                    cmd.reject_code = REJ_DEPTH;
                end
                else
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.fits)
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_SRC_W;
                    state_next  = S_DIV_W;
                end
                else if (status.k_at_max)
                begin
                    cmd.emit_reject = 1'b1;
                    cmd.reject_code = REJ_TOO_LARGE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.k_inc = 1'b1;
                end
            end
            S_DIV_W:
            begin
                if (status.div_done)
                begin
                    cmd.cap_w   = 1'b1;
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_SRC_H;
                    state_next  = S_DIV_H;
                end
            end
            S_DIV_H:
            begin
                if (status.div_done)
                begin
                    cmd.cap_h   = 1'b1;
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_SRC_S;
                    state_next  = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                if (status.div_done)
                begin
                    cmd.cap_s  = 1'b1;
                    state_next = S_WINDOW;
                end
            end
            S_WINDOW:
            begin
                cmd.emit_window = 1'b1;
                state_next      = status.stride_zero ? S_IDLE : S_DATA;
            end
            default:
            begin
                state_next = S_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> tb/tb_bmp_stream_decimate_to_rgb565_unit.sv
`timescale 1ns / 1ps

module tb_bmp_stream_decimate_to_rgb565_unit;
    import bsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS = 70;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PIXELS,
        ST_DONE
    } dec_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_ready;
    in_word_t              byte_word = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_word_t             result_word;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // decoder mirror: configuration and per-image state
    logic [11:0] scr_w = SCREEN_W_RESET;
    logic [11:0] scr_h = SCREEN_H_RESET;
    logic [3:0]  skip_max = MAX_SKIP_RESET;
    logic [31:0] pos_ctr;
    logic [31:0] hdr_reg [6];
    logic [31:0] k_sel;
    logic [31:0] scaled_w;
    logic [31:0] stride_b;
    logic [31:0] row_idx;
    logic [31:0] col_byte;
    logic [15:0] bg_hold;
    dec_state_t  dec_state;

    out_word_t   pending_results [$];
    out_word_t   want_word;
    out_word_t   made_word;
    bit          made;
    logic [7:0]  file_q [$];

    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    bmp_stream_decimate_to_rgb565_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** bmp_stream_decimate_to_rgb565_unit: FAILED **");
            $finish;
        end
    end

    function automatic void restart_decoder();
        pos_ctr = '0;
        foreach (hdr_reg[i])
            hdr_reg[i] = '0;
        k_sel = '0;
        scaled_w = '0;
        stride_b = '0;
        row_idx = '0;
        col_byte = '0;
        bg_hold = '0;
        dec_state = ST_HEADER;
    endfunction

    function automatic void decode_byte(input in_word_t w, output bit produced,
                                        output out_word_t r);
        logic [31:0] b, pos, start, k1, col, lane, last_row;
        logic [31:0] img_w, img_h, sh_h, k, sw32, sh32;
        bit fits;
        produced = 1'b0;
        r = '0;
        b = {24'd0, w.file_byte};
        if (w.first_byte)
            restart_decoder();
        pos = pos_ctr;
        if (pos_ctr != 32'hFFFF_FFFF)
            pos_ctr++;
        if (dec_state == ST_HEADER)
        begin
            if (pos == 0)
                hdr_reg[3] |= b << 24;
            else if (pos == 1)
                hdr_reg[3] |= b << 16;
            else if (pos >= 10 && pos <= 13)
                hdr_reg[0] |= b << (8 * (pos - 10));
            else if (pos >= 18 && pos <= 21)
                hdr_reg[1] |= b << (8 * (pos - 18));
            else if (pos >= 22 && pos <= 25)
                hdr_reg[2] |= b << (8 * (pos - 22));
            else if (pos >= 28 && pos <= 29)
                hdr_reg[3] |= b << (8 * (pos - 28));
            else if (pos >= 30 && pos <= 33)
                hdr_reg[4] |= b << (8 * (pos - 30));
            else if (pos >= 34 && pos <= 37)
                hdr_reg[5] |= b << (8 * (pos - 34));
            if (pos == HEADER_LAST)
            begin
                produced = 1'b1;
                img_w = hdr_reg[1];
                img_h = hdr_reg[2];
                sw32 = {20'd0, scr_w};
                sh32 = {20'd0, scr_h};
                r.kind = KIND_REJECT;
                dec_state = ST_DONE;
                if (hdr_reg[3][31:16] != BMP_SIGNATURE)
                    r.reject_code = REJ_SIGNATURE;
                else if (hdr_reg[4] != 0)
                    r.reject_code = REJ_COMPRESSED;
                else if (hdr_reg[5] == 0 || img_h == 0)
                    r.reject_code = REJ_NO_DATA;
                else if (hdr_reg[3][15:0] != BMP_DEPTH_24)
                    r.reject_code = REJ_DEPTH;
                else
                begin
                    fits = 1'b0;
                    k = 0;
                    while (!fits && k <= {28'd0, skip_max})
                    begin
                        if (img_w / (k + 1) <= sw32 && img_h / (k + 1) <= sh32)
                            fits = 1'b1;
                        else
                            k++;
                    end
                    if (!fits)
                        r.reject_code = REJ_TOO_LARGE;
                    else
                    begin
                        k_sel = k;
                        scaled_w = img_w / (k + 1);
                        sh_h = img_h / (k + 1);
                        stride_b = hdr_reg[5] / img_h;
                        row_idx = '0;
                        col_byte = '0;
                        dec_state = (stride_b != 0) ? ST_PIXELS : ST_DONE;
                        r.kind = KIND_WINDOW;
                        r.x_start = 12'((sw32 - scaled_w) / 2);
                        r.y_start = 12'((sh32 - sh_h) / 2);
                        r.x_end = 12'((sw32 + scaled_w) / 2 - 1);
                        r.y_end = 12'((sh32 + sh_h) / 2);
                    end
                end
            end
        end
        else if (dec_state == ST_PIXELS)
        begin
            start = (hdr_reg[0] < DATA_MIN_START) ? DATA_MIN_START : hdr_reg[0];
            if (pos >= start)
            begin
                k1 = k_sel + 1;
                col = col_byte / 3;
                lane = col_byte % 3;
                if (lane == 0)
                    bg_hold[7:0] = b[7:0];
                else if (lane == 1)
                    bg_hold[15:8] = b[7:0];
                else if (row_idx % k1 == 0 && col % k1 == 0 && col / k1 < scaled_w)
                begin
                    produced = 1'b1;
                    r.kind = KIND_PIXEL;
                    r.pixel = {b[7:3], bg_hold[15:10], bg_hold[7:3]};
                    last_row = ((hdr_reg[2] - 1) / k1) * k1;
                    r.last = (row_idx == last_row && col / k1 == scaled_w - 1);
                end
                col_byte++;
                if (col_byte >= stride_b)
                begin
                    col_byte = '0;
                    row_idx++;
                    if (row_idx >= hdr_reg[2])
                        dec_state = ST_DONE;
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", result_word);
                    fail_count++;
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    if (result_word.kind !== want_word.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want_word.kind, result_word.kind);
                        fail_count++;
                    end
                    if (result_word.pixel !== want_word.pixel)
                    begin
                        $error("pixel: expected %h, got %h", want_word.pixel, result_word.pixel);
                        fail_count++;
                    end
                    if (result_word.x_start !== want_word.x_start)
                    begin
                        $error("x_start: expected %0d, got %0d",
                               want_word.x_start, result_word.x_start);
                        fail_count++;
                    end
                    if (result_word.y_start !== want_word.y_start)
                    begin
                        $error("y_start: expected %0d, got %0d",
                               want_word.y_start, result_word.y_start);
                        fail_count++;
                    end
                    if (result_word.x_end !== want_word.x_end)
                    begin
                        $error("x_end: expected %0d, got %0d", want_word.x_end, result_word.x_end);
                        fail_count++;
                    end
                    if (result_word.y_end !== want_word.y_end)
                    begin
                        $error("y_end: expected %0d, got %0d", want_word.y_end, result_word.y_end);
                        fail_count++;
                    end
                    if (result_word.reject_code !== want_word.reject_code)
                    begin
                        $error("reject_code: expected %0d, got %0d",
                               want_word.reject_code, result_word.reject_code);
                        fail_count++;
                    end
                    if (result_word.last !== want_word.last)
                    begin
                        $error("last: expected %0d, got %0d", want_word.last, result_word.last);
                        fail_count++;
                    end
                end
            end
            if (byte_valid && byte_ready)
            begin
                decode_byte(byte_word, made, made_word);
                if (made)
                    pending_results.push_back(made_word);
            end
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_byte(input logic [7:0] value, input logic mark);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_word <= {value, mark};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCREEN_W: scr_w = value[11:0];
            REG_SCREEN_H: scr_h = value[11:0];
            REG_MAX_SKIP: skip_max = value[3:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_le(input logic [31:0] value, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(value[8*i +: 8]);
    endfunction

    // header in bytes 0..37, then body bytes (padding, pixel rows, trailing junk)
    task automatic send_file(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] depth, input logic [31:0] comp,
                             input logic [31:0] size, input int body, input bit mark);
        file_q = {};
        file_q.push_back(sig[15:8]);
        file_q.push_back(sig[7:0]);
        push_le($urandom(), 4);
        push_le($urandom(), 4);
        push_le(offset, 4);
        push_le($urandom(), 4);
        push_le(w, 4);
        push_le(h, 4);
        push_le($urandom(), 2);
        push_le({16'd0, depth}, 2);
        push_le(comp, 4);
        push_le(size, 4);
        for (int i = 0; i < body; i++)
            file_q.push_back(8'($urandom_range(0, 255)));
        foreach (file_q[i])
            send_byte(file_q[i], (i == 0) && mark);
    endtask

    task automatic random_file(input int max_w, input int max_h);
        int roll, w, h, stride, size, offset, body, code;
        logic [15:0] sig, depth;
        logic [31:0] comp, wv, hv, sz;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            w = $urandom_range(0, max_w);
            h = $urandom_range(1, max_h);
            case ($urandom_range(0, 9))
                7, 8: stride = 3 * w + $urandom_range(0, 5) - 2;
                9: stride = 0;
                default: stride = (3 * w + 3) / 4 * 4;
            endcase
            if (stride < 0)
                stride = 0;
            size = stride * h + $urandom_range(0, h - 1);
            offset = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : 54;
            body = (offset > 38 ? offset - 38 : 0) + size;
            if ($urandom_range(0, 9) == 0)
                body = $urandom_range(0, body);
            send_file(BMP_SIGNATURE, offset, w, h, BMP_DEPTH_24, 0, size,
                      body + $urandom_range(0, 3), $urandom_range(0, 19) != 0);
        end
        else if (roll < 90)
        begin
            code = $urandom_range(0, 4);
            sig = BMP_SIGNATURE;
            comp = 0;
            depth = BMP_DEPTH_24;
            sz = $urandom_range(1, 64);
            wv = $urandom_range(0, 8);
            hv = $urandom_range(1, 8);
            // later checks broken too at random, the first failing one must win
            if (code == REJ_TOO_LARGE || (code < REJ_TOO_LARGE && $urandom_range(0, 1)))
            begin
                if ($urandom_range(0, 1))
                    wv = $urandom() | 32'h0001_0000;
                else
                    hv = $urandom() | 32'h0001_0000;
            end
            if (code == REJ_DEPTH || (code < REJ_DEPTH && $urandom_range(0, 1)))
            begin
                depth = 16'($urandom_range(0, 65535));
                if (depth == BMP_DEPTH_24)
                    depth = 16'd32;
            end
            if (code == REJ_NO_DATA || (code < REJ_NO_DATA && $urandom_range(0, 1)))
            begin
                if ($urandom_range(0, 1))
                    sz = 0;
                else
                    hv = 0;
            end
            if (code == REJ_COMPRESSED || (code < REJ_COMPRESSED && $urandom_range(0, 1)))
                comp = $urandom() | (32'd1 << $urandom_range(0, 31));
            if (code == REJ_SIGNATURE)
            begin
                sig = 16'($urandom_range(0, 65535));
                if (sig == BMP_SIGNATURE)
                    sig[0] = ~sig[0];
            end
            send_file(sig, 54, wv, hv, depth, comp, sz, $urandom_range(0, 6), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_unmarked_start();
        idle_pct = 16;
        stall_pct = 16;
        send_file(BMP_SIGNATURE, 54, 2, 2, BMP_DEPTH_24, 0, 16, 16 + 16 + 2, 1'b0);
        // data offset inside the header
        send_file(BMP_SIGNATURE, 0, 2, 2, BMP_DEPTH_24, 0, 16, 18, 1'b1);
        settle();
    endtask

    task automatic test_reject_order();
        send_file(16'h4D42, 54, 2, 2, BMP_DEPTH_24, 1, 16, 1, 1'b1);
        send_file(BMP_SIGNATURE, 54, 2, 2, BMP_DEPTH_24, 32'h8000_0000, 0, 1, 1'b1);
        send_file(BMP_SIGNATURE, 54, 2, 0, 16'd0, 0, 16, 1, 1'b1);
        send_file(BMP_SIGNATURE, 54, 2, 2, BMP_DEPTH_24, 0, 0, 1, 1'b1);
        send_file(BMP_SIGNATURE, 54, 32'hFFFF_FFFF, 2, 16'hFFFF, 0, 16, 1, 1'b1);
        send_file(BMP_SIGNATURE, 54, 32'hFFFF_FFFF, 2, BMP_DEPTH_24, 0, 16, 1, 1'b1);
        settle();
    endtask

    task automatic test_size_extremes();
        write_reg(REG_SCREEN_W, 32'd4095);
        write_reg(REG_SCREEN_H, 32'd4095);
        write_reg(REG_MAX_SKIP, 32'd15);
        send_file(BMP_SIGNATURE, 54, 65520, 1, BMP_DEPTH_24, 0, 1, 16 + 3, 1'b1);
        send_file(BMP_SIGNATURE, 54, 65536, 1, BMP_DEPTH_24, 0, 1, 1, 1'b1);
        settle();
        write_reg(REG_SCREEN_W, 32'd1);
        write_reg(REG_SCREEN_H, 32'd1);
        write_reg(REG_MAX_SKIP, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        // zero width, x_end wraps
        send_file(BMP_SIGNATURE, 38, 0, 1, BMP_DEPTH_24, 0, 3, 5, 1'b1);
        // stride too short for the only pixel
        send_file(BMP_SIGNATURE, 54, 1, 1, BMP_DEPTH_24, 0, 2, 16 + 4, 1'b1);
        settle();
    endtask

    task automatic test_decimation();
        write_reg(REG_SCREEN_W, 32'd4);
        write_reg(REG_SCREEN_H, 32'd3);
        write_reg(REG_MAX_SKIP, 32'd15);
        send_file(BMP_SIGNATURE, 54, 9, 5, BMP_DEPTH_24, 0, 140, 16 + 140 + 2, 1'b1);
        // stride zero
        send_file(BMP_SIGNATURE, 54, 1, 3, BMP_DEPTH_24, 0, 2, 16 + 4, 1'b1);
        settle();
        write_reg(REG_MAX_SKIP, 32'd0);
        send_file(BMP_SIGNATURE, 54, 9, 5, BMP_DEPTH_24, 0, 140, 3, 1'b1);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_SCREEN_W, {20'hABCDE, SCREEN_W_RESET});
        write_reg(REG_SCREEN_H, {20'h54321, SCREEN_H_RESET});
        write_reg(REG_MAX_SKIP, {28'h9876543, MAX_SKIP_RESET});
        idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_left = 400;
        send_file(BMP_SIGNATURE, 54, 8, 4, BMP_DEPTH_24, 0, 96, 16 + 96, 1'b1);
        settle();
    endtask

    task automatic test_random_streams();
        int idle_tab [4];
        int stall_tab [4];
        int first;
        idle_tab = '{0, 66, 0, 16};
        stall_tab = '{0, 0, 66, 16};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph % 2 == 0)
            begin
                write_reg(REG_SCREEN_W, ($urandom() & ~32'hFFF) | $urandom_range(1, 6));
                write_reg(REG_SCREEN_H, ($urandom() & ~32'hFFF) | $urandom_range(1, 4));
            end
            else
            begin
                write_reg(REG_SCREEN_W, ($urandom() & ~32'hFFF) | $urandom_range(1, 4095));
                write_reg(REG_SCREEN_H, ($urandom() & ~32'hFFF) | $urandom_range(1, 4095));
            end
            write_reg(REG_MAX_SKIP, ($urandom() & ~32'hF) | $urandom_range(0, 15));
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS)
                random_file(10, 6);
            settle();
        end
    endtask

    initial
    begin
        restart_decoder();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_unmarked_start();
        test_reject_order();
        test_size_extremes();
        test_decimation();
        test_output_backpressure();
        test_random_streams();
        if (fail_count == 0)
            $display("** bmp_stream_decimate_to_rgb565_unit: PASSED **");
        else
            $display("** bmp_stream_decimate_to_rgb565_unit: FAILED **");
        $finish;
    end

endmodule
